@@ rtl/fwslp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fwslp_pkg
// Shared types and constants of the FIFO window hash set.
// ----------------------------------------------------------------------------
package fwslp_pkg;
    localparam int KEY_W  = 31;
    localparam int WIN_W  = 7;
    localparam int FIFO_DEPTH = 64;
    localparam int FIFO_AW = 6;

    typedef enum logic [1:0] {
        ST_EMPTY = 2'd0,
        ST_OCC   = 2'd1,
        ST_TOMB  = 2'd2
    } t_slot_st;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_PROBE,
        S_FIFO_WAIT,
        S_EV_LOAD,
        S_EV_PROBE,
        S_INS_PROBE,
        S_DONE
    } t_state;

    // Probe modes of the datapath walker.
    typedef enum logic [1:0] {
        PM_FIND,
        PM_FREE
    } t_pmode;

    typedef struct packed {
        logic      load_key;   // capture input key and start its home slot
        logic      hash_old;   // start the home slot of the FIFO head key
        logic      load_home;  // start walk at the computed home slot
        logic      save_home;  // keep the computed home slot of the input key
        logic      restart;    // restart walk for the captured input key
        logic      step;       // advance one slot
        t_pmode    mode;
        logic      clear;      // current slot becomes empty
        logic      mark_tomb;  // current slot becomes a tombstone
        logic      write_occ;  // store input key in current slot
        logic      fifo_rd;    // read head entry
        logic      pop;
        logic      push;
        logic      set_hit;
        logic      set_ev;
        logic      clr_result;
    } t_cmd;

    typedef struct packed {
        logic match;     // current slot is occupied and holds the probe key
        logic stop;      // slot empty (find) or not occupied (free)
        logic last;      // walk has visited every slot
        logic need_pop;  // fifo holds the effective window
        logic can_push;
    } t_sts;
endpackage
`default_nettype wire

@@ rtl/fwslp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fwslp_in_if / fwslp_out_if
// Valid/ready channels for keys and results.
// ----------------------------------------------------------------------------
interface fwslp_in_if;
    logic        valid;
    logic        ready;
    logic [30:0] key_in;
    modport source (output valid, output key_in, input ready);
    modport sink (input valid, input key_in, output ready);
endinterface

interface fwslp_out_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic        evicted_valid;
    logic [30:0] evicted_key;
    logic [6:0]  occupancy;
    modport source (output valid, output hit, output evicted_valid,
                    output evicted_key, output occupancy, input ready);
    modport sink (input valid, input hit, input evicted_valid,
                  input evicted_key, input occupancy, output ready);
endinterface
`default_nettype wire

@@ rtl/fifo_window_set_linear_probe_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_window_set_linear_probe_unit
// FIFO window of recent distinct keys held in a linear-probing hash set.
// ----------------------------------------------------------------------------
// Sequence: a hit walks P slots; a miss with room walks P, then I; a miss that evicts
//   walks P, E and I; P, E and I are the lookup, eviction and insertion walks (one slot per cycle).
// Handshake: the next key is accepted in the cycle after the result is taken.
// Reset: synchronous active low; FIFO empty, window 64, and the slot table is
//   cleared slot by slot after reset while the input is held off.
// ----------------------------------------------------------------------------
module fifo_window_set_linear_probe_unit #(
    parameter int TABLE_SIZE = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [6:0] i_cfg_wdata,
    fwslp_in_if.sink        in_if,
    fwslp_out_if.source     out_if
);
    import fwslp_pkg::*;

    logic [WIN_W-1:0] r_window;
    t_cmd w_cmd;
    t_sts w_sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_window <= WIN_W'(64);
        else if (i_cfg_we) r_window <= i_cfg_wdata;
    end

    fwslp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_if.valid),
        .o_in_ready  (in_if.ready),
        .o_out_valid (out_if.valid),
        .i_out_ready (out_if.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    fwslp_datapath #(.TABLE_SIZE(TABLE_SIZE)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key       (in_if.key_in),
        .i_window    (r_window),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_hit       (out_if.hit),
        .o_ev_valid  (out_if.evicted_valid),
        .o_ev_key    (out_if.evicted_key),
        .o_occupancy (out_if.occupancy)
    );
endmodule
`default_nettype wire

@@ rtl/fwslp_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fwslp_datapath
// Slot table, FIFO memory, home slot unit, probe walker and result registers.
// ----------------------------------------------------------------------------
module fwslp_datapath #(
    parameter int TABLE_SIZE = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [30:0]           i_key,
    input  wire logic [6:0]            i_window,
    input  wire fwslp_pkg::t_cmd       i_cmd,
    output fwslp_pkg::t_sts            o_sts,
    output logic                       o_hit,
    output logic                       o_ev_valid,
    output logic [30:0]                o_ev_key,
    output logic [6:0]                 o_occupancy
);
    import fwslp_pkg::*;

    localparam int SW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CW = $clog2(TABLE_SIZE + 1);
    localparam logic [SW-1:0] LAST_SLOT = SW'(TABLE_SIZE - 1);
    localparam logic [SW-1:0] TS_LOW = SW'(TABLE_SIZE);
    // Rounded-up reciprocal; the quotient it gives is exact for every key.
    localparam logic [31:0] RECIP =
        32'(((64'd1 << (KEY_W + SW)) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE));
    localparam logic [WIN_W-1:0] TS_CAP =
        (TABLE_SIZE < FIFO_DEPTH) ? WIN_W'(TABLE_SIZE) : WIN_W'(FIFO_DEPTH);

    logic [KEY_W-1:0]   r_slot_keys [TABLE_SIZE];
    logic [KEY_W-1:0]   r_fifo_keys [FIFO_DEPTH];
    t_slot_st           r_status [TABLE_SIZE];
    logic [FIFO_AW-1:0] r_head;
    logic [WIN_W-1:0]   r_count;
    logic [KEY_W-1:0]   r_key;
    logic [KEY_W-1:0]   r_probe_key;
    logic [KEY_W-1:0]   r_fifo_q;
    logic [SW-1:0]      r_slot;
    logic [CW-1:0]      r_steps;
    logic [KEY_W-1:0]   r_skey_q;
    t_slot_st           r_st_q;
    logic [KEY_W-1:0]   r_hsrc;
    logic [KEY_W-1:0]   r_hq;
    logic [SW-1:0]      r_home_key;
    logic               r_hit;
    logic               r_ev;
    logic [KEY_W-1:0]   r_ev_key;
    logic [WIN_W-1:0]   w_eff;
    logic [KEY_W-1:0]   w_hash_in;
    logic [62:0]        w_prod;
    logic [2*SW-1:0]    w_qt;
    logic [SW-1:0]      w_home;
    logic [SW-1:0]      w_rd_slot;
    logic               w_st_we;
    t_slot_st           w_st_wd;

    always_comb begin
        w_eff = (i_window == '0) ? WIN_W'(1) : i_window;
        if (w_eff > WIN_W'(FIFO_DEPTH)) w_eff = WIN_W'(FIFO_DEPTH);
        if (w_eff > TS_CAP) w_eff = TS_CAP;
    end

    // For the home slot the quotient is registered first, and the remainder
    // needs only the low slot bits of key minus quotient times table size.
    assign w_hash_in = i_cmd.load_key ? i_key : r_fifo_q;
    assign w_prod = 63'(w_hash_in) * 63'(RECIP);
    assign w_qt = {{SW{1'b0}}, r_hq[SW-1:0]} * {{SW{1'b0}}, TS_LOW};
    assign w_home = r_hsrc[SW-1:0] - w_qt[SW-1:0];

    // Slot that the walker holds next cycle; the table is read there so the
    // registered contents line up with r_slot.
    always_comb begin
        w_rd_slot = r_slot;
        if (i_cmd.load_home) w_rd_slot = w_home;
        else if (i_cmd.restart) w_rd_slot = r_home_key;
        else if (i_cmd.step) w_rd_slot = (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
    end

    always_comb begin
        w_st_we = i_cmd.clear || i_cmd.mark_tomb || i_cmd.write_occ;
        if (i_cmd.write_occ) w_st_wd = ST_OCC;
        else if (i_cmd.mark_tomb) w_st_wd = ST_TOMB;
        else w_st_wd = ST_EMPTY;
    end

    always_comb begin
        o_sts.match = (r_st_q == ST_OCC) && (r_skey_q == r_probe_key);
        o_sts.stop = (i_cmd.mode == PM_FIND) ? (r_st_q == ST_EMPTY)
                                             : (r_st_q != ST_OCC);
        o_sts.last = (r_steps >= CW'(TABLE_SIZE - 1));
        o_sts.need_pop = (r_count >= w_eff) && (r_count != '0);
        o_sts.can_push = (r_count < WIN_W'(FIFO_DEPTH));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_count <= '0;
            r_slot <= '0;
            r_steps <= '0;
        end else begin
            if (i_cmd.pop) begin
                r_head <= r_head + 1'b1;
            end
            if (i_cmd.pop && !i_cmd.push) r_count <= r_count - 1'b1;
            if (i_cmd.push && !i_cmd.pop) r_count <= r_count + 1'b1;
            r_slot <= w_rd_slot;
            if (i_cmd.load_home || i_cmd.restart) r_steps <= '0;
            else if (i_cmd.step) r_steps <= r_steps + 1'b1;
        end
    end

    // A write to the slot being read is forwarded to the read register.
    always_ff @(posedge i_clk) begin
        if (w_st_we) r_status[r_slot] <= w_st_wd;
        if (i_cmd.write_occ) r_slot_keys[r_slot] <= r_key;
        if (w_st_we && (w_rd_slot == r_slot)) r_st_q <= w_st_wd;
        else r_st_q <= r_status[w_rd_slot];
        if (i_cmd.write_occ && (w_rd_slot == r_slot)) r_skey_q <= r_key;
        else r_skey_q <= r_slot_keys[w_rd_slot];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) r_fifo_keys[FIFO_AW'(r_head + r_count[FIFO_AW-1:0])] <= r_key;
        if (i_cmd.fifo_rd) r_fifo_q <= r_fifo_keys[r_head];
        if (i_cmd.load_key) r_key <= i_key;
        if (i_cmd.load_key || i_cmd.hash_old) begin
            r_hsrc <= w_hash_in;
            r_hq <= KEY_W'(w_prod >> (KEY_W + SW));
        end
        if (i_cmd.load_home) begin
            r_probe_key <= r_hsrc;
            if (i_cmd.save_home) r_home_key <= w_home;
        end else if (i_cmd.restart) begin
            r_probe_key <= r_key;
        end
        if (i_cmd.clr_result) begin
            r_hit <= 1'b0;
            r_ev <= 1'b0;
            r_ev_key <= '0;
        end else begin
            if (i_cmd.set_hit) r_hit <= 1'b1;
            if (i_cmd.set_ev) begin
                r_ev <= 1'b1;
                r_ev_key <= r_fifo_q;
            end
        end
    end

    assign o_hit = r_hit;
    assign o_ev_valid = r_ev;
    assign o_ev_key = r_ev_key;
    assign o_occupancy = r_count;
endmodule
`default_nettype wire

@@ rtl/fwslp_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fwslp_ctrl
// Sequencer: table clear, lookup walk, eviction walk, insertion walk, result
// handoff.
// ----------------------------------------------------------------------------
module fwslp_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    input  wire fwslp_pkg::t_sts  i_sts,
    output fwslp_pkg::t_cmd       o_cmd
);
    import fwslp_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_cmd.mode = PM_FIND;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                o_cmd.step = 1'b1;
                if (i_sts.last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_key = 1'b1;
                    o_cmd.clr_result = 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load_home = 1'b1;
                o_cmd.save_home = 1'b1;
                n_state = S_PROBE;
            end
            S_PROBE: begin
                if (i_sts.match) begin
                    o_cmd.set_hit = 1'b1;
                    n_state = S_DONE;
                end else if (i_sts.stop || i_sts.last) begin
                    if (i_sts.need_pop) begin
                        o_cmd.fifo_rd = 1'b1;
                        n_state = S_FIFO_WAIT;
                    end else begin
                        o_cmd.restart = 1'b1;
                        n_state = S_INS_PROBE;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_FIFO_WAIT: begin
                o_cmd.hash_old = 1'b1;
                o_cmd.set_ev = 1'b1;
                o_cmd.pop = 1'b1;
                n_state = S_EV_LOAD;
            end
            S_EV_LOAD: begin
                o_cmd.load_home = 1'b1;
                n_state = S_EV_PROBE;
            end
            S_EV_PROBE: begin
                if (i_sts.match) begin
                    o_cmd.mark_tomb = 1'b1;
                    o_cmd.restart = 1'b1;
                    n_state = S_INS_PROBE;
                end else if (i_sts.stop || i_sts.last) begin
                    o_cmd.restart = 1'b1;
                    n_state = S_INS_PROBE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_INS_PROBE: begin
                o_cmd.mode = PM_FREE;
                if (!i_sts.can_push) begin
                    n_state = S_DONE;
                end else if (i_sts.stop) begin
                    o_cmd.write_occ = 1'b1;
                    o_cmd.push = 1'b1;
                    n_state = S_DONE;
                end else if (i_sts.last) begin
                    o_cmd.push = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_DONE: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

@@ verif/fifo_window_set_linear_probe_checker.sv @@
// ----------------------------------------------------------------------------
// fifo_window_set_linear_probe_checker
// Watches the key and result channels and the window register writes. It
// keeps its own copy of the hash set and FIFO window, predicts each result,
// and compares the results in order.
// ----------------------------------------------------------------------------
module fifo_window_set_linear_probe_checker #(
    parameter int TABLE_SIZE = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_wdata,
    fwslp_in_if        in_if,
    fwslp_out_if       out_if,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import fwslp_pkg::*;

    typedef struct packed {
        logic              hit;
        logic              evicted_valid;
        logic [KEY_W-1:0]  evicted_key;
        logic [WIN_W-1:0]  occupancy;
    } t_lookup_result;

    logic [KEY_W-1:0]   set_keys [TABLE_SIZE];
    t_slot_st           set_state [TABLE_SIZE];
    logic [KEY_W-1:0]   window_keys [FIFO_DEPTH];
    logic [FIFO_AW-1:0] window_head;
    int unsigned        window_count;
    logic [WIN_W-1:0]   window_limit;
    t_lookup_result     expected_results [$];

    assign o_pending = expected_results.size();

    // Returns the slot holding the key, or TABLE_SIZE when absent.
    function automatic int locate_key(logic [KEY_W-1:0] key);
        int s;
        s = key % TABLE_SIZE;
        for (int n = 0; n < TABLE_SIZE; n++) begin
            if (set_state[s] == ST_EMPTY) return TABLE_SIZE;
            if (set_state[s] == ST_OCC && set_keys[s] == key) return s;
            s = (s + 1) % TABLE_SIZE;
        end
        return TABLE_SIZE;
    endfunction

    function automatic t_lookup_result admit_key(logic [KEY_W-1:0] key);
        t_lookup_result r;
        int unsigned lim;
        int s;
        logic [KEY_W-1:0] old;
        r = '0;
        if (locate_key(key) < TABLE_SIZE) begin
            r.hit = 1'b1;
        end else begin
            lim = (window_limit == 0) ? 1 : window_limit;
            if (lim > FIFO_DEPTH) lim = FIFO_DEPTH;
            if (lim > TABLE_SIZE) lim = TABLE_SIZE;
            if (window_count >= lim && window_count > 0) begin
                old = window_keys[window_head];
                s = locate_key(old);
                if (s < TABLE_SIZE) set_state[s] = ST_TOMB;
                window_head++;
                window_count--;
                r.evicted_valid = 1'b1;
                r.evicted_key = old;
            end
            if (window_count < FIFO_DEPTH) begin
                window_keys[FIFO_AW'(window_head + window_count)] = key;
                window_count++;
                s = key % TABLE_SIZE;
                for (int n = 0; n < TABLE_SIZE; n++) begin
                    if (set_state[s] != ST_OCC) begin
                        set_state[s] = ST_OCC;
                        set_keys[s] = key;
                        break;
                    end
                    s = (s + 1) % TABLE_SIZE;
                end
            end
        end
        r.occupancy = WIN_W'(window_count);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_lookup_result want;
        if (!i_rst_n) begin
            foreach (set_state[i]) set_state[i] = ST_EMPTY;
            window_head = '0;
            window_count = 0;
            window_limit = 7'd64;
            expected_results.delete();
        end else begin
            if (i_cfg_we) window_limit = i_cfg_wdata;
            if (in_if.valid && in_if.ready)
                expected_results.push_back(admit_key(in_if.key_in));
            if (out_if.valid && out_if.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result transaction with nothing expected", $realtime);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (out_if.hit !== want.hit)
                        report_mismatch("hit", out_if.hit, want.hit);
                    if (out_if.evicted_valid !== want.evicted_valid)
                        report_mismatch("evicted_valid", out_if.evicted_valid,
                                        want.evicted_valid);
                    if (out_if.evicted_key !== want.evicted_key)
                        report_mismatch("evicted_key", out_if.evicted_key,
                                        want.evicted_key);
                    if (out_if.occupancy !== want.occupancy)
                        report_mismatch("occupancy", out_if.occupancy, want.occupancy);
                end
            end
        end
    end
endmodule

@@ verif/fifo_window_set_linear_probe_unit_tb.sv @@
// ----------------------------------------------------------------------------
// fifo_window_set_linear_probe_unit_tb
// Drives keys through the FIFO window hash set with random gaps and stalls,
// over several window settings, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module fifo_window_set_linear_probe_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SIZE = 64;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [6:0] i_cfg_wdata;
    int         fail_count;
    int         pending;
    logic       hold_results;

    fwslp_in_if  in_if ();
    fwslp_out_if out_if ();

    fifo_window_set_linear_probe_unit #(.TABLE_SIZE(TABLE_SIZE)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .in_if       (in_if),
        .out_if      (out_if)
    );

    fifo_window_set_linear_probe_checker #(.TABLE_SIZE(TABLE_SIZE)) checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .in_if        (in_if),
        .out_if       (out_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: random stalls, plus a long hold-off while hold_results is set.
    initial begin
        int gap;
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_results) begin
                out_if.ready <= 1'b0;
            end else if (out_if.ready && !out_if.valid) begin
                out_if.ready <= 1'b1;
            end else begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
                if (out_if.ready && gap != 0) begin
                    out_if.ready <= 1'b0;
                    repeat (gap - 1) @(posedge i_clk);
                end
                out_if.ready <= 1'b1;
            end
        end
    end

    // Offers one key and waits for its transaction. Valid stays high after
    // the transaction until the next gap or drain lowers it.
    task automatic send_key(logic [30:0] key, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid  <= 1'b1;
        in_if.key_in <= key;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_window(logic [6:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Keys drawn from a small pool so hits and collisions are common.
    function automatic logic [30:0] random_key(int pool);
        case ($urandom_range(0, 9))
            0: return 31'($urandom());
            1: return 31'h7FFF_FFC0 | 31'($urandom_range(0, 63));
            default: return 31'($urandom_range(0, pool - 1)) * 31'(TABLE_SIZE)
                            / 31'($urandom_range(1, 8)) + 31'($urandom_range(0, 3));
        endcase
    endfunction

    initial begin
        logic [6:0] windows [8];
        windows      = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd5, 7'd65, 7'd20, 7'd3};
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        in_if.valid  = 1'b0;
        in_if.key_in = '0;
        hold_results = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, a repeat for a hit, colliding home slots.
        send_key(31'd0, 0);
        send_key(31'h7FFF_FFFF, 0);
        send_key(31'd0, 0);
        send_key(31'd64, 0);
        send_key(31'd128, 0);
        send_key(31'h7FFF_FFBF, 0);
        send_key(31'h5555_5555, 0);
        send_key(31'h2AAA_AAAA, 0);
        send_key(31'd63, 0);
        send_key(31'd64, 0);

        // Long hold-off on the result side while keys keep coming.
        hold_results = 1'b1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                hold_results = 1'b0;
            end
            for (int i = 0; i < 6; i++) send_key(random_key(8), 1);
        join

        // Window shrunk below occupancy, then set to one.
        write_window(7'd2);
        for (int i = 0; i < 8; i++) send_key(31'(1000 + i), 0);
        write_window(7'd1);
        send_key(31'd5, 0);
        send_key(31'd5, 0);
        send_key(31'd6, 0);

        for (int p = 0; p < 8; p++) begin
            write_window(windows[p]);
            for (int i = 0; i < 185; i++) begin
                if (i == 90) drain_results();
                send_key(random_key(4 + 4 * p), $urandom_range(0, 4) == 0);
            end
        end
        drain_results();

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

@@ files.f @@
rtl/fwslp_pkg.sv
rtl/fwslp_if.sv
rtl/fwslp_datapath.sv
rtl/fwslp_ctrl.sv
rtl/fifo_window_set_linear_probe_unit.sv
verif/fifo_window_set_linear_probe_checker.sv
verif/fifo_window_set_linear_probe_unit_tb.sv
